// ===== hw/rtl/tbs_pkg.sv =====
// shared types, codes and constants for the tilt balance sequencer
package tbs_pkg;

  localparam int TIMER_BITS = 16;
  localparam int REG_BITS   = 16;
  localparam int ANGLE_BITS = 24;
  localparam int CMP_BITS   = (TIMER_BITS > REG_BITS) ? TIMER_BITS : REG_BITS;
  localparam int IDX_BITS   = 2;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam logic [REG_BITS-1:0] MARGIN_RESET    = REG_BITS'(250);
  localparam logic [REG_BITS-1:0] BD_TICKS_RESET  = REG_BITS'(25);
  localparam logic [REG_BITS-1:0] STOP_TICKS_RESET = REG_BITS'(50);

  localparam logic [IDX_BITS-1:0] REG_LEVEL_MARGIN    = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_BACKDRIVE_TICKS = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_STOP_TICKS      = 2'd2;

  typedef enum logic [2:0] {
    PH_WAIT      = 3'd0,
    PH_BALANCE   = 3'd1,
    PH_BACKDRIVE = 3'd2,
    PH_STOP      = 3'd3,
    PH_FINAL     = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_JOYSTICK   = 3'd1,
    CMD_BACK       = 3'd2,
    CMD_FORWARD    = 3'd3,
    CMD_BD_BACK    = 3'd4,
    CMD_BD_FORWARD = 3'd5,
    CMD_STOP       = 3'd6
  } cmd_t;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_BACK = 2'd1;
  localparam logic [1:0] DIR_FWD  = 2'd2;

  typedef struct packed {
    logic [REG_BITS-1:0] level_margin;
    logic [REG_BITS-1:0] backdrive_ticks;
    logic [REG_BITS-1:0] stop_ticks;
  } cfg_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] tilt_angle;
    logic                         hold_button;
    logic                         active;
  } tick_t;

  typedef struct packed {
    phase_t                phase;
    logic [1:0]            last_direction;
    logic [TIMER_BITS-1:0] backdrive_count;
    logic                  backdrive_running;
    logic [TIMER_BITS-1:0] stop_count;
    logic                  stop_running;
  } seq_state_t;

endpackage

// ===== hw/rtl/tilt_balance_sequencer.sv =====
// top level: input stage, sequencer state, result register
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  in       | in_valid / in_stall       | tilt_angle, hold_button, active
//  out      | out_valid / out_stall     | drive_command, phase
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one tick per cycle while out_stall is low; an accepted tick passes the input
// register, then the result register, with the single compare-and-select
// pass between them. rst is synchronous: it empties both stages,
// returns the sequencer to wait and loads the register defaults. out_stall
// holds the result; in_stall rises only when both stages are full and held.
module tilt_balance_sequencer import tbs_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ANGLE_BITS-1:0] tilt_angle,
  input  logic                         hold_button,
  input  logic                         active,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   drive_command,
  output logic [2:0]                   phase,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [IDX_BITS-1:0]          cfg_index,
  input  logic [REG_BITS-1:0]          cfg_data
);

  cfg_t       cfg;
  tick_t      s1_item;
  logic       s1_valid;
  logic       out_take;
  seq_state_t state;
  seq_state_t state_next;
  cmd_t       cmd;

  tbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tbs_step_logic u_step (
    .cfg        (cfg),
    .item       (s1_item),
    .state      (state),
    .state_next (state_next),
    .cmd        (cmd)
  );

  assign out_take = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.tilt_angle  <= tilt_angle;
      s1_item.hold_button <= hold_button;
      s1_item.active      <= active;
    end
  end

  // sequencer state advances when the staged beat moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase             <= PH_WAIT;
      state.last_direction    <= DIR_NONE;
      state.backdrive_count   <= '0;
      state.backdrive_running <= 1'b0;
      state.stop_count        <= '0;
      state.stop_running      <= 1'b0;
    end else if (s1_valid && out_take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_take) begin
      drive_command <= cmd;
      phase         <= state_next.phase;
    end
  end

`ifndef SYNTH
  a_stop_timer_only_in_stop: assert property (@(posedge clk) disable iff (rst)
    (state.phase != PH_STOP) |-> !state.stop_running)
    else $error("stop timer running outside stop phase");

  a_bd_count_only_in_backdrive: assert property (@(posedge clk) disable iff (rst)
    (state.phase != PH_BACKDRIVE) |-> (state.backdrive_count == '0))
    else $error("backdrive count left over outside backdrive phase");

  a_timers_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(state.backdrive_running && state.stop_running))
    else $error("both timers running");

  a_inactive_holds_state: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_take && !s1_item.active) |=> $stable(state))
    else $error("inactive tick changed sequencer state");
`endif

endmodule

// ===== hw/rtl/tbs_cfg_regs.sv =====
// configuration registers: margin and the two timer limits
module tbs_cfg_regs import tbs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0] cfg_data,
  output cfg_t                cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_margin    <= MARGIN_RESET;
      cfg.backdrive_ticks <= BD_TICKS_RESET;
      cfg.stop_ticks      <= STOP_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEVEL_MARGIN:    cfg.level_margin    <= cfg_data;
        REG_BACKDRIVE_TICKS: cfg.backdrive_ticks <= cfg_data;
        REG_STOP_TICKS:      cfg.stop_ticks      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/tbs_step_logic.sv =====
// next-state and drive command for one tick
module tbs_step_logic import tbs_pkg::*; (
  input  cfg_t       cfg,
  input  tick_t      item,
  input  seq_state_t state,
  output seq_state_t state_next,
  output cmd_t       cmd
);

  logic signed [ANGLE_BITS:0] angle_x;
  logic signed [ANGLE_BITS:0] margin_pos;
  logic signed [ANGLE_BITS:0] margin_neg;
  logic                       level;
  logic                       at_or_above;
  logic                       at_or_below;
  logic                       bd_done;
  logic                       stop_done;
  seq_state_t                 s;

  assign angle_x     = {item.tilt_angle[ANGLE_BITS-1], item.tilt_angle};
  assign margin_pos  = {{(ANGLE_BITS+1-REG_BITS){1'b0}}, cfg.level_margin};
  assign margin_neg  = -margin_pos;
  assign at_or_above = angle_x >= margin_pos;
  assign at_or_below = angle_x <= margin_neg;
  assign level       = (angle_x <= margin_pos) && (angle_x >= margin_neg);

  assign bd_done   = CMP_BITS'(state.backdrive_count) >= CMP_BITS'(cfg.backdrive_ticks);
  assign stop_done = CMP_BITS'(state.stop_count) >= CMP_BITS'(cfg.stop_ticks);

  always_comb begin
    s   = state;
    cmd = CMD_NONE;
    if (item.active) begin
      case (state.phase)
        PH_WAIT: begin
          cmd = CMD_JOYSTICK;
          if (item.hold_button && !level) s.phase = PH_BALANCE;
        end
        PH_BALANCE: begin
          if (level) begin
            s.phase = PH_BACKDRIVE;
          end else if (at_or_above) begin
            cmd              = CMD_BACK;
            s.last_direction = DIR_BACK;
          end else if (at_or_below) begin
            cmd              = CMD_FORWARD;
            s.last_direction = DIR_FWD;
          end
        end
        PH_BACKDRIVE: begin
          // backdrive opposite to the last balancing direction
          if (state.last_direction == DIR_FWD) begin
            cmd                 = CMD_BD_BACK;
            s.backdrive_running = 1'b1;
            s.last_direction    = DIR_NONE;
          end else if (state.last_direction == DIR_BACK) begin
            cmd                 = CMD_BD_FORWARD;
            s.backdrive_running = 1'b1;
            s.last_direction    = DIR_NONE;
          end
          if (bd_done) begin
            s.backdrive_running = 1'b0;
            s.backdrive_count   = '0;
            s.phase             = PH_STOP;
            s.stop_count        = '0;
            s.stop_running      = 1'b1;
          end
        end
        PH_STOP: begin
          cmd = CMD_STOP;
          if (stop_done || !item.hold_button) begin
            s.stop_running = 1'b0;
            s.stop_count   = '0;
            s.phase        = PH_FINAL;
          end
        end
        PH_FINAL: begin
          s.phase = (level || !item.hold_button) ? PH_WAIT : PH_BALANCE;
        end
        default: begin
          s.phase = PH_WAIT;
        end
      endcase
      // timers count at the end of the tick and saturate
      if (s.backdrive_running && (s.backdrive_count != TIMER_MAX)) begin
        s.backdrive_count = s.backdrive_count + TIMER_BITS'(1);
      end
      if (s.stop_running && (s.stop_count != TIMER_MAX)) begin
        s.stop_count = s.stop_count + TIMER_BITS'(1);
      end
    end
    state_next = s;
  end

endmodule
